/* rtl/adit_pkg.sv */
// ----------------------------------------------------------------------------
// adit_pkg
// Shared types and constants of the aging device identifier table.
// ----------------------------------------------------------------------------
package adit_pkg;

    localparam int UUID_W     = 64;
    localparam int AGE_W      = 8;
    localparam int ACTION_W   = 2;
    localparam int RD_IDX_W   = 4;
    localparam int OUT_CNT_W  = 5;

    localparam logic [AGE_W-1:0] AGE_MAX       = 8'hFF;
    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 8'd10;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BEACON = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_BEACON  = 2'd1,
        CELL_INC     = 2'd2,
        CELL_COMPACT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic               pick_match;
        logic [UUID_W-1:0]  uuid_high;
        logic [UUID_W-1:0]  uuid_low;
        logic [AGE_W-1:0]   timeout;
    } t_cell_ctrl;

endpackage

/* rtl/adit_cell.sv */
// ----------------------------------------------------------------------------
// adit_cell
// One table entry: identifier and age, with match, expiry and a shift-down
// chain that pulls the upper neighbor's entry in during compaction.
// ----------------------------------------------------------------------------
module adit_cell (
    input  logic                            i_clk,
    input  adit_pkg::t_cell_ctrl            i_ctrl,
    input  logic                            i_live,
    input  logic                            i_append,
    input  logic                            i_shift_in,
    input  logic [adit_pkg::UUID_W-1:0]     i_nb_high,
    input  logic [adit_pkg::UUID_W-1:0]     i_nb_low,
    input  logic [adit_pkg::AGE_W-1:0]      i_nb_age,
    output logic [adit_pkg::UUID_W-1:0]     o_high,
    output logic [adit_pkg::UUID_W-1:0]     o_low,
    output logic [adit_pkg::AGE_W-1:0]      o_age,
    output logic                            o_match,
    output logic                            o_shift_out
);

    logic [adit_pkg::UUID_W-1:0] r_high, n_high;
    logic [adit_pkg::UUID_W-1:0] r_low,  n_low;
    logic [adit_pkg::AGE_W-1:0]  r_age,  n_age;
    logic                        match;
    logic                        expired;
    logic                        shift_self;

    always_comb begin
        match      = i_live && (r_high == i_ctrl.uuid_high) && (r_low == i_ctrl.uuid_low);
        expired    = i_live && (r_age > i_ctrl.timeout);
        shift_self = i_shift_in | (i_ctrl.pick_match ? match : expired);
        n_high     = r_high;
        n_low      = r_low;
        n_age      = r_age;
        case (i_ctrl.op)
            adit_pkg::CELL_BEACON: begin
                if (match) begin
                    n_age = '0;
                end else if (i_append) begin
                    n_high = i_ctrl.uuid_high;
                    n_low  = i_ctrl.uuid_low;
                    n_age  = '0;
                end
            end
            adit_pkg::CELL_INC: begin
                if (r_age != adit_pkg::AGE_MAX) begin
                    n_age = r_age + 8'd1;
                end
            end
            adit_pkg::CELL_COMPACT: begin
                if (shift_self) begin
                    n_high = i_nb_high;
                    n_low  = i_nb_low;
                    n_age  = i_nb_age;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_high <= n_high;
        r_low  <= n_low;
        r_age  <= n_age;
    end

    assign o_high      = r_high;
    assign o_low       = r_low;
    assign o_age       = r_age;
    assign o_match     = match;
    assign o_shift_out = shift_self;

endmodule

/* rtl/aging_device_id_table.sv */
// ----------------------------------------------------------------------------
// aging_device_id_table
// Ordered table of 128-bit device identifiers with per-entry age and a shared timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one action per transaction:
//   beacon, remove, tick or read. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result per action. The configuration channel
//   (i_cfg_valid / o_cfg_ready) writes timeout_ticks; write it only while idle.
//   Entries sit in a row of cells; removal shifts the upper cells down by one.
//   Each action is accepted in S_IDLE, runs in S_EXEC and has its result
//   registered in S_RESULT; a tick also passes through S_TRIM, one compaction
//   step per expired entry plus one empty check. The block takes one action at
//   a time and accepts the next one the cycle after the result is registered.
//   The result may still wait in the output register at that point.
//   If the receiver stalls, the result holds in the output register and a
//   finished action waits until that register frees up.
//   Reset empties the table and sets timeout_ticks to 10; no clearing pass.
// ----------------------------------------------------------------------------
module aging_device_id_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [adit_pkg::ACTION_W-1:0]       i_action,
    input  logic [adit_pkg::UUID_W-1:0]         i_uuid_high,
    input  logic [adit_pkg::UUID_W-1:0]         i_uuid_low,
    input  logic [adit_pkg::RD_IDX_W-1:0]       i_read_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [adit_pkg::OUT_CNT_W-1:0]      o_entry_total,
    output logic                                o_hit,
    output logic                                o_added,
    output logic                                o_dropped,
    output logic [adit_pkg::OUT_CNT_W-1:0]      o_expired_total,
    output logic                                o_read_valid,
    output logic [adit_pkg::UUID_W-1:0]         o_read_uuid_high,
    output logic [adit_pkg::UUID_W-1:0]         o_read_uuid_low,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [adit_pkg::AGE_W-1:0]          i_cfg_timeout_ticks
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > adit_pkg::RD_IDX_W) ? CNT_W : adit_pkg::RD_IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TRIM,
        S_RESULT
    } t_state;

    t_state                         r_state;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               r_expired;
    logic [adit_pkg::AGE_W-1:0]     r_timeout;
    adit_pkg::t_action              r_action;
    logic [adit_pkg::UUID_W-1:0]    r_uuid_high;
    logic [adit_pkg::UUID_W-1:0]    r_uuid_low;
    logic [adit_pkg::RD_IDX_W-1:0]  r_read_index;
    logic                           r_hit;
    logic                           r_added;
    logic                           r_dropped;
    logic                           r_out_valid;

    adit_pkg::t_cell_ctrl           cell_ctrl;
    logic [adit_pkg::UUID_W-1:0]    cell_high [TABLE_ENTRIES];
    logic [adit_pkg::UUID_W-1:0]    cell_low  [TABLE_ENTRIES];
    logic [adit_pkg::AGE_W-1:0]     cell_age  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]       cell_match;
    logic [TABLE_ENTRIES-1:0]       cell_live;
    logic [TABLE_ENTRIES-1:0]       cell_append;
    logic [TABLE_ENTRIES:0]         shift_chain;
    logic                           any_match;
    logic                           read_ok;
    logic [adit_pkg::UUID_W-1:0]    read_high;
    logic [adit_pkg::UUID_W-1:0]    read_low;
    logic                           out_free;

    assign any_match      = |cell_match;
    assign shift_chain[0] = 1'b0;

    always_comb begin
        cell_ctrl.op         = adit_pkg::CELL_HOLD;
        cell_ctrl.pick_match = (r_action == adit_pkg::ACT_REMOVE);
        cell_ctrl.uuid_high  = r_uuid_high;
        cell_ctrl.uuid_low   = r_uuid_low;
        cell_ctrl.timeout    = r_timeout;
        case (r_state)
            S_EXEC: begin
                case (r_action)
                    adit_pkg::ACT_BEACON: cell_ctrl.op = adit_pkg::CELL_BEACON;
                    adit_pkg::ACT_REMOVE: cell_ctrl.op = adit_pkg::CELL_COMPACT;
                    adit_pkg::ACT_TICK:   cell_ctrl.op = adit_pkg::CELL_INC;
                    default:              cell_ctrl.op = adit_pkg::CELL_HOLD;
                endcase
            end
            S_TRIM: begin
                cell_ctrl.op = adit_pkg::CELL_COMPACT;
            end
            default: begin
                cell_ctrl.op = adit_pkg::CELL_HOLD;
            end
        endcase
    end

    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
            localparam int NB = (k + 1 < TABLE_ENTRIES) ? k + 1 : k;

            assign cell_live[k]   = (CNT_W'(k) < r_count);
            assign cell_append[k] = (CNT_W'(k) == r_count) && !any_match;

            adit_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (cell_ctrl),
                .i_live      (cell_live[k]),
                .i_append    (cell_append[k]),
                .i_shift_in  (shift_chain[k]),
                .i_nb_high   (cell_high[NB]),
                .i_nb_low    (cell_low[NB]),
                .i_nb_age    (cell_age[NB]),
                .o_high      (cell_high[k]),
                .o_low       (cell_low[k]),
                .o_age       (cell_age[k]),
                .o_match     (cell_match[k]),
                .o_shift_out (shift_chain[k+1])
            );
        end
    endgenerate

    always_comb begin
        read_ok   = (r_action == adit_pkg::ACT_READ) &&
                    (CMP_W'(r_read_index) < CMP_W'(r_count));
        read_high = '0;
        read_low  = '0;
        for (int j = 0; j < TABLE_ENTRIES; j++) begin
            if (read_ok && (CMP_W'(j) == CMP_W'(r_read_index))) begin
                read_high = read_high | cell_high[j];
                read_low  = read_low  | cell_low[j];
            end
        end
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_expired   <= '0;
            r_timeout   <= adit_pkg::TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_timeout_ticks;
            end
            if (r_out_valid && !i_out_stall && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_action     <= adit_pkg::t_action'(i_action);
                        r_uuid_high  <= i_uuid_high;
                        r_uuid_low   <= i_uuid_low;
                        r_read_index <= i_read_index;
                        r_state      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_expired <= '0;
                    case (r_action)
                        adit_pkg::ACT_BEACON: begin
                            r_hit     <= any_match;
                            r_added   <= !any_match && (r_count < CNT_W'(TABLE_ENTRIES));
                            r_dropped <= !any_match && !(r_count < CNT_W'(TABLE_ENTRIES));
                            r_state   <= S_RESULT;
                            if (!any_match && (r_count < CNT_W'(TABLE_ENTRIES))) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                        adit_pkg::ACT_REMOVE: begin
                            r_hit     <= shift_chain[TABLE_ENTRIES];
                            r_added   <= 1'b0;
                            r_dropped <= 1'b0;
                            r_state   <= S_RESULT;
                            if (shift_chain[TABLE_ENTRIES]) begin
                                r_count <= r_count - CNT_W'(1);
                            end
                        end
                        adit_pkg::ACT_TICK: begin
                            r_hit     <= 1'b0;
                            r_added   <= 1'b0;
                            r_dropped <= 1'b0;
                            r_state   <= S_TRIM;
                        end
                        default: begin
                            r_hit     <= 1'b0;
                            r_added   <= 1'b0;
                            r_dropped <= 1'b0;
                            r_state   <= S_RESULT;
                        end
                    endcase
                end
                S_TRIM: begin
                    if (shift_chain[TABLE_ENTRIES]) begin
                        r_count   <= r_count - CNT_W'(1);
                        r_expired <= r_expired + CNT_W'(1);
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        o_entry_total    <= adit_pkg::OUT_CNT_W'(r_count);
                        o_hit            <= r_hit;
                        o_added          <= r_added;
                        o_dropped        <= r_dropped;
                        o_expired_total  <= adit_pkg::OUT_CNT_W'(r_expired);
                        o_read_valid     <= read_ok;
                        o_read_uuid_high <= read_high;
                        o_read_uuid_low  <= read_low;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count exceeds table size");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones({o_hit | o_added | o_dropped, o_read_valid,
                                     o_expired_total != '0}) <= 1))
        else $error("result mixes fields of different actions");

    a_trim_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM && shift_chain[TABLE_ENTRIES]) |=>
            (r_count == $past(r_count) - CNT_W'(1)))
        else $error("compaction step did not drop one entry");

    a_add_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_added && o_dropped))
        else $error("beacon both added and dropped");
`endif

endmodule
